// ===== sv/bss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack package
// Shared widths, command and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned PTR_W    = $clog2(DEPTH + 1);
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned MIN_W    = 17;
  localparam int unsigned ENTRY_W  = CODE_W + AGE_W;
  localparam int unsigned SUM_W    = $clog2(DEPTH * ((1 << AGE_W) - 1) + 1);
  localparam int unsigned DCNT_W   = $clog2(SUM_W);

  localparam logic [MIN_W-1:0] MIN_NONE = MIN_W'(100000);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 3'd0,
    CMD_PUSH   = 3'd1,
    CMD_POP    = 3'd2,
    CMD_SEARCH = 3'd3,
    CMD_SPLIT  = 3'd4,
    CMD_STATS  = 3'd5
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [AGE_W-1:0]  age;
  } entry_t;

  // One datapath operation per cycle, issued by the controller.
  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_CLEAR,
    DP_PUSH,
    DP_FULL,
    DP_EMPTY,
    DP_OK,
    DP_POP_RD,
    DP_POP_CAP,
    DP_SCAN_INIT,
    DP_SRCH_RD,
    DP_SRCH_CHK,
    DP_SRCH_END,
    DP_SPLIT,
    DP_SUM_RD,
    DP_SUM_ACC,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_END,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             full;
    logic             empty;
    logic             scan_done;
    logic             match;
    logic             found;
    logic             div_last;
    logic             out_free;
    logic             res_last;
  } dp_stat_t;

endpackage

// ===== sv/bss_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack channels
// Valid/ready command channel and result channel.
// ----------------------------------------------------------------------------
interface bss_in_if;
  logic                    valid;
  logic                    ready;
  logic [bss_pkg::CMD_W-1:0]  command;
  logic [bss_pkg::CODE_W-1:0] item_code;
  logic [bss_pkg::AGE_W-1:0]  item_age;

  modport source (output valid, output command, output item_code, output item_age,
                  input ready);
  modport sink   (input valid, input command, input item_code, input item_age,
                  output ready);
endinterface

interface bss_out_if;
  logic                       valid;
  logic                       ready;
  logic [bss_pkg::ST_W-1:0]   status;
  logic [bss_pkg::CODE_W-1:0] out_code;
  logic [bss_pkg::AGE_W-1:0]  out_age;
  logic [bss_pkg::PTR_W-1:0]  depth_used;
  logic [bss_pkg::PTR_W-1:0]  second_used;
  logic [bss_pkg::AGE_W-1:0]  max_age_seen;
  logic [bss_pkg::MIN_W-1:0]  min_age_seen;
  logic [bss_pkg::AGE_W-1:0]  mean_age;
  logic                       last;

  modport source (output valid, output status, output out_code, output out_age,
                  output depth_used, output second_used, output max_age_seen,
                  output min_age_seen, output mean_age, output last, input ready);
  modport sink   (input valid, input status, input out_code, input out_age,
                  input depth_used, input second_used, input max_age_seen,
                  input min_age_seen, input mean_age, input last, output ready);
endinterface

// ===== sv/bounded_stack_with_search_stats.sv =====
`timescale 1ns / 1ps
// Each item is loaded, dispatched and emitted: clear, push, split and unknown commands
// go straight to emit, pop reads and captures the top entry first, search checks each
// entry in turn, stats sums every entry and then runs a restoring divider. One item is in
// work at a time; the next is taken the cycle after its last result is registered,
// while that result waits. Reset clears both stack counts, the age maximum to 0 and
// minimum to 100000; the stack memory is not initialized.
// ----------------------------------------------------------------------------
// Bounded stack with search and age statistics
// Top level: controller, datapath and the valid/ready channels.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_stats (
  input  logic      clk_i,
  input  logic      rst_ni,
  bss_in_if.sink    in_i,
  bss_out_if.source out_o
);
  import bss_pkg::*;

  dp_op_e   op;
  dp_stat_t stat;

  bss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .stat_i    (stat),
    .op_o      (op)
  );

  bss_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .stat_o        (stat),
    .command_i     (in_i.command),
    .item_code_i   (in_i.item_code),
    .item_age_i    (in_i.item_age),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .status_o      (out_o.status),
    .out_code_o    (out_o.out_code),
    .out_age_o     (out_o.out_age),
    .depth_used_o  (out_o.depth_used),
    .second_used_o (out_o.second_used),
    .max_age_seen_o(out_o.max_age_seen),
    .min_age_seen_o(out_o.min_age_seen),
    .mean_age_o    (out_o.mean_age),
    .last_o        (out_o.last)
  );

endmodule

// ===== sv/bss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bss_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack datapath
// Stack memory, pointers, age extremes, scan and divide registers, and the
// result output register.
// ----------------------------------------------------------------------------
module bss_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bss_pkg::dp_op_e            op_i,
  output bss_pkg::dp_stat_t          stat_o,
  input  logic [bss_pkg::CMD_W-1:0]  command_i,
  input  logic [bss_pkg::CODE_W-1:0] item_code_i,
  input  logic [bss_pkg::AGE_W-1:0]  item_age_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [bss_pkg::ST_W-1:0]   status_o,
  output logic [bss_pkg::CODE_W-1:0] out_code_o,
  output logic [bss_pkg::AGE_W-1:0]  out_age_o,
  output logic [bss_pkg::PTR_W-1:0]  depth_used_o,
  output logic [bss_pkg::PTR_W-1:0]  second_used_o,
  output logic [bss_pkg::AGE_W-1:0]  max_age_seen_o,
  output logic [bss_pkg::MIN_W-1:0]  min_age_seen_o,
  output logic [bss_pkg::AGE_W-1:0]  mean_age_o,
  output logic                       last_o
);
  import bss_pkg::*;

  // Latched command.
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [AGE_W-1:0]  age_q, age_d;

  // Architectural state. The second stack's contents are never read back,
  // so only its fill count is kept.
  logic [PTR_W-1:0]  main_top_q, main_top_d;
  logic [PTR_W-1:0]  sec_top_q, sec_top_d;
  logic [AGE_W-1:0]  max_q, max_d;
  logic [MIN_W-1:0]  min_q, min_d;

  // Scan, search and divide state.
  logic [PTR_W-1:0]  idx_q, idx_d;
  logic              found_q, found_d;
  entry_t            pend_q, pend_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [PTR_W-1:0]  rem_q, rem_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;

  // Prepared result.
  status_e           res_st_q, res_st_d;
  entry_t            res_ent_q, res_ent_d;
  logic [AGE_W-1:0]  res_mean_q, res_mean_d;
  logic              res_last_q, res_last_d;

  // Output register.
  logic              ov_q, ov_d;
  status_e           o_st_q, o_st_d;
  entry_t            o_ent_q, o_ent_d;
  logic [PTR_W-1:0]  o_depth_q, o_depth_d;
  logic [PTR_W-1:0]  o_sec_q, o_sec_d;
  logic [AGE_W-1:0]  o_max_q, o_max_d;
  logic [MIN_W-1:0]  o_min_q, o_min_d;
  logic [AGE_W-1:0]  o_mean_q, o_mean_d;
  logic              o_last_q, o_last_d;

  // Memory port.
  logic              we;
  logic [ADDR_W-1:0] raddr;
  entry_t            rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  logic [PTR_W-1:0]  top_m1;
  logic [PTR_W-1:0]  half;
  logic [PTR_W-1:0]  room;
  logic [PTR_W-1:0]  moved;
  logic [PTR_W:0]    div_tmp;
  logic              div_ge;
  logic              out_free;

  assign rdata    = entry_t'(rdata_raw);
  assign top_m1   = main_top_q - PTR_W'(1);
  assign half     = main_top_q >> 1;
  assign room     = PTR_W'(DEPTH) - sec_top_q;
  assign moved    = (half > room) ? room : half;
  assign div_tmp  = {rem_q, dvd_q[SUM_W-1]};
  assign div_ge   = (div_tmp >= {1'b0, main_top_q});
  assign out_free = !ov_q || out_ready_i;

  bss_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_main_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(main_top_q[ADDR_W-1:0]),
    .wdata_i({code_q, age_q}),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  always_comb begin
    cmd_d      = cmd_q;
    code_d     = code_q;
    age_d      = age_q;
    main_top_d = main_top_q;
    sec_top_d  = sec_top_q;
    max_d      = max_q;
    min_d      = min_q;
    idx_d      = idx_q;
    found_d    = found_q;
    pend_d     = pend_q;
    sum_d      = sum_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    res_st_d   = res_st_q;
    res_ent_d  = res_ent_q;
    res_mean_d = res_mean_q;
    res_last_d = res_last_q;
    ov_d       = ov_q && !out_ready_i;
    o_st_d     = o_st_q;
    o_ent_d    = o_ent_q;
    o_depth_d  = o_depth_q;
    o_sec_d    = o_sec_q;
    o_max_d    = o_max_q;
    o_min_d    = o_min_q;
    o_mean_d   = o_mean_q;
    o_last_d   = o_last_q;
    we         = 1'b0;
    raddr      = idx_q[ADDR_W-1:0];

    case (op_i)
      DP_LOAD: begin
        cmd_d  = command_i;
        code_d = item_code_i;
        age_d  = item_age_i;
      end
      DP_CLEAR, DP_OK, DP_FULL, DP_EMPTY, DP_PUSH: begin
        res_st_d   = (op_i == DP_FULL) ? ST_FULL : ((op_i == DP_EMPTY) ? ST_EMPTY : ST_OK);
        res_ent_d  = '0;
        res_mean_d = '0;
        res_last_d = 1'b1;
        if (op_i == DP_CLEAR) begin
          main_top_d = '0;
        end
        if (op_i == DP_PUSH) begin
          we         = 1'b1;
          main_top_d = main_top_q + PTR_W'(1);
          if (MIN_W'(age_q) < min_q) begin
            min_d = MIN_W'(age_q);
          end
          if (age_q > max_q) begin
            max_d = age_q;
          end
        end
      end
      DP_POP_RD: begin
        raddr      = top_m1[ADDR_W-1:0];
        main_top_d = top_m1;
      end
      DP_POP_CAP: begin
        res_st_d   = ST_OK;
        res_ent_d  = rdata;
        res_mean_d = '0;
        res_last_d = 1'b1;
      end
      DP_SCAN_INIT: begin
        idx_d   = '0;
        found_d = 1'b0;
        sum_d   = '0;
      end
      DP_SRCH_RD, DP_SUM_RD: begin
        raddr = idx_q[ADDR_W-1:0];
      end
      DP_SRCH_CHK: begin
        idx_d = idx_q + PTR_W'(1);
        // A match is held back until the next one shows whether it is the last.
        if (rdata.code == code_q) begin
          pend_d  = rdata;
          found_d = 1'b1;
          if (found_q) begin
            res_st_d   = ST_OK;
            res_ent_d  = pend_q;
            res_mean_d = '0;
            res_last_d = 1'b0;
          end
        end
      end
      DP_SRCH_END: begin
        res_st_d   = found_q ? ST_OK : ST_NOT_FOUND;
        res_ent_d  = found_q ? pend_q : '0;
        res_mean_d = '0;
        res_last_d = 1'b1;
      end
      DP_SPLIT: begin
        // Half of the entries leave the main stack; those that do not fit on
        // the second stack are dropped.
        main_top_d = main_top_q - half;
        sec_top_d  = sec_top_q + moved;
        res_st_d   = (half > room) ? ST_FULL : ST_OK;
        res_ent_d  = '0;
        res_mean_d = '0;
        res_last_d = 1'b1;
      end
      DP_SUM_ACC: begin
        sum_d = sum_q + SUM_W'(rdata.age);
        idx_d = idx_q + PTR_W'(1);
      end
      DP_DIV_INIT: begin
        dvd_d  = sum_q;
        rem_d  = '0;
        dcnt_d = '0;
      end
      DP_DIV_STEP: begin
        // Restoring division, one quotient bit per cycle.
        rem_d  = div_ge ? PTR_W'(div_tmp - {1'b0, main_top_q}) : div_tmp[PTR_W-1:0];
        dvd_d  = {dvd_q[SUM_W-2:0], div_ge};
        dcnt_d = dcnt_q + DCNT_W'(1);
      end
      DP_DIV_END: begin
        res_st_d   = ST_OK;
        res_ent_d  = '0;
        res_mean_d = dvd_q[AGE_W-1:0];
        res_last_d = 1'b1;
      end
      DP_EMIT: begin
        ov_d      = 1'b1;
        o_st_d    = res_st_q;
        o_ent_d   = res_ent_q;
        o_depth_d = main_top_q;
        o_sec_d   = sec_top_q;
        o_max_d   = max_q;
        o_min_d   = min_q;
        o_mean_d  = res_mean_q;
        o_last_d  = res_last_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_top_q <= '0;
      sec_top_q  <= '0;
      max_q      <= '0;
      min_q      <= MIN_NONE;
      idx_q      <= '0;
      found_q    <= 1'b0;
      dcnt_q     <= '0;
      res_last_q <= 1'b1;
      ov_q       <= 1'b0;
    end else begin
      main_top_q <= main_top_d;
      sec_top_q  <= sec_top_d;
      max_q      <= max_d;
      min_q      <= min_d;
      idx_q      <= idx_d;
      found_q    <= found_d;
      dcnt_q     <= dcnt_d;
      res_last_q <= res_last_d;
      ov_q       <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    code_q     <= code_d;
    age_q      <= age_d;
    pend_q     <= pend_d;
    sum_q      <= sum_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    res_st_q   <= res_st_d;
    res_ent_q  <= res_ent_d;
    res_mean_q <= res_mean_d;
    o_st_q     <= o_st_d;
    o_ent_q    <= o_ent_d;
    o_depth_q  <= o_depth_d;
    o_sec_q    <= o_sec_d;
    o_max_q    <= o_max_d;
    o_min_q    <= o_min_d;
    o_mean_q   <= o_mean_d;
    o_last_q   <= o_last_d;
  end

  always_comb begin
    stat_o.cmd       = cmd_q;
    stat_o.full      = (main_top_q == PTR_W'(DEPTH));
    stat_o.empty     = (main_top_q == '0);
    stat_o.scan_done = (idx_q == main_top_q);
    stat_o.match     = (rdata.code == code_q);
    stat_o.found     = found_q;
    stat_o.div_last  = (dcnt_q == DCNT_W'(SUM_W - 1));
    stat_o.out_free  = out_free;
    stat_o.res_last  = res_last_q;
  end

  assign out_valid_o    = ov_q;
  assign status_o       = o_st_q;
  assign out_code_o     = o_ent_q.code;
  assign out_age_o      = o_ent_q.age;
  assign depth_used_o   = o_depth_q;
  assign second_used_o  = o_sec_q;
  assign max_age_seen_o = o_max_q;
  assign min_age_seen_o = o_min_q;
  assign mean_age_o     = o_mean_q;
  assign last_o         = o_last_q;

endmodule

// ===== sv/bss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack controller
// Sequences each command through datapath operations, one item at a time.
// ----------------------------------------------------------------------------
module bss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bss_pkg::dp_stat_t stat_i,
  output bss_pkg::dp_op_e   op_o
);
  import bss_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_POP_CAP,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SUM_RD,
    S_SUM_ACC,
    S_DIV,
    S_DIV_END,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    op_o    = DP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = DP_LOAD;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_EMIT;
        case (stat_i.cmd)
          CMD_CLEAR: op_o = DP_CLEAR;
          CMD_PUSH:  op_o = stat_i.full ? DP_FULL : DP_PUSH;
          CMD_POP: begin
            if (stat_i.empty) begin
              op_o = DP_EMPTY;
            end else begin
              op_o    = DP_POP_RD;
              state_d = S_POP_CAP;
            end
          end
          CMD_SEARCH: begin
            op_o    = DP_SCAN_INIT;
            state_d = S_SRCH_RD;
          end
          CMD_SPLIT: op_o = DP_SPLIT;
          CMD_STATS: begin
            if (stat_i.empty) begin
              op_o = DP_EMPTY;
            end else begin
              op_o    = DP_SCAN_INIT;
              state_d = S_SUM_RD;
            end
          end
          default: op_o = DP_OK;
        endcase
      end
      S_POP_CAP: begin
        op_o    = DP_POP_CAP;
        state_d = S_EMIT;
      end
      S_SRCH_RD: begin
        if (stat_i.scan_done) begin
          op_o    = DP_SRCH_END;
          state_d = S_EMIT;
        end else begin
          op_o    = DP_SRCH_RD;
          state_d = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        op_o    = DP_SRCH_CHK;
        state_d = (stat_i.match && stat_i.found) ? S_EMIT : S_SRCH_RD;
      end
      S_SUM_RD: begin
        if (stat_i.scan_done) begin
          op_o    = DP_DIV_INIT;
          state_d = S_DIV;
        end else begin
          op_o    = DP_SUM_RD;
          state_d = S_SUM_ACC;
        end
      end
      S_SUM_ACC: begin
        op_o    = DP_SUM_ACC;
        state_d = S_SUM_RD;
      end
      S_DIV: begin
        op_o = DP_DIV_STEP;
        if (stat_i.div_last) begin
          state_d = S_DIV_END;
        end
      end
      S_DIV_END: begin
        op_o    = DP_DIV_END;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          op_o    = DP_EMIT;
          // A search result that is not the last resumes the scan.
          state_d = stat_i.res_last ? S_IDLE : S_SRCH_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== sv/bss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack checker
// Port-level assertions on the top level, attached by bind.
// ----------------------------------------------------------------------------
module bss_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [bss_pkg::ST_W-1:0]   status_i,
  input logic [bss_pkg::CODE_W-1:0] out_code_i,
  input logic [bss_pkg::PTR_W-1:0]  depth_used_i,
  input logic [bss_pkg::PTR_W-1:0]  second_used_i,
  input logic                       last_i
);
  import bss_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(out_code_i) && $stable(last_i))
    else $error("stalled result changed");

  // Only one item is in work: acceptance closes the input until it is done.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted twice in a row");

  // A miss is a single, final result with no code.
  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_NOT_FOUND) |-> last_i && (out_code_i == '0))
    else $error("not-found result malformed");

  // Fill counts never exceed the stack depth.
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (depth_used_i <= PTR_W'(DEPTH)) && (second_used_i <= PTR_W'(DEPTH)))
    else $error("stack count out of range");

endmodule

bind bounded_stack_with_search_stats bss_checker u_bss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .status_i     (out_o.status),
  .out_code_i   (out_o.out_code),
  .depth_used_i (out_o.depth_used),
  .second_used_i(out_o.second_used),
  .last_i       (out_o.last)
);

// ===== dv/bounded_stack_with_search_stats_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded stack testbench
// Drives command items into the stack and checks every result item against
// a cycle-free shadow of the main stack, the spill stack and the age extremes.
// Both channels stall at random. One stretch runs without gaps, the result
// side is held off once, and the command side drains twice.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_stats_tb;
  import bss_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int unsigned IDLE_PCT    = 26;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 1500;

  typedef struct {
    status_e           status;
    logic [CODE_W-1:0] code;
    logic [AGE_W-1:0]  age;
    logic [PTR_W-1:0]  depth;
    logic [PTR_W-1:0]  second;
    logic [AGE_W-1:0]  max_age;
    logic [MIN_W-1:0]  min_age;
    logic [AGE_W-1:0]  mean;
    logic              last;
  } stack_result_t;

  logic clk_i;
  logic rst_ni;

  bss_in_if  cmd_if ();
  bss_out_if res_if ();

  bounded_stack_with_search_stats dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // Shadow state of the block.
  logic [CODE_W-1:0] shadow_code [DEPTH];
  logic [AGE_W-1:0]  shadow_age  [DEPTH];
  int unsigned       shadow_top;
  logic [CODE_W-1:0] spill_code  [DEPTH];
  logic [AGE_W-1:0]  spill_age   [DEPTH];
  int unsigned       spill_top;
  logic [AGE_W-1:0]  age_max_seen;
  logic [MIN_W-1:0]  age_min_seen;

  stack_result_t pending_results [$];
  stack_result_t oldest;

  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned stall_cycles;
  int unsigned cmd_seen [8];
  int unsigned full_hits, empty_hits, miss_hits, lossy_splits, longest_match;

  logic        steady_flow;
  logic        hold_wanted;
  int unsigned hold_left;

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic stack_result_t shape_result(status_e st, logic [CODE_W-1:0] code,
                                                 logic [AGE_W-1:0] age,
                                                 logic [AGE_W-1:0] mean, logic last);
    stack_result_t r;
    r.status  = st;
    r.code    = code;
    r.age     = age;
    r.depth   = PTR_W'(shadow_top);
    r.second  = PTR_W'(spill_top);
    r.max_age = age_max_seen;
    r.min_age = age_min_seen;
    r.mean    = mean;
    r.last    = last;
    return r;
  endfunction

  function automatic void track_age_extremes(logic [AGE_W-1:0] age);
    if (MIN_W'(age) < age_min_seen) age_min_seen = MIN_W'(age);
    if (age > age_max_seen) age_max_seen = age;
  endfunction

  task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                                 input logic [AGE_W-1:0] age);
    stack_result_t hits [$];
    int unsigned   half;
    int unsigned   age_sum;
    status_e       split_status;
    cmd_seen[cmd]++;
    case (cmd)
      CMD_CLEAR: begin
        shadow_top = 0;
        pending_results.push_back(shape_result(ST_OK, '0, '0, '0, 1'b1));
      end
      CMD_PUSH: begin
        if (shadow_top >= DEPTH) begin
          full_hits++;
          pending_results.push_back(shape_result(ST_FULL, '0, '0, '0, 1'b1));
        end else begin
          shadow_code[shadow_top] = code;
          shadow_age[shadow_top]  = age;
          shadow_top++;
          track_age_extremes(age);
          pending_results.push_back(shape_result(ST_OK, '0, '0, '0, 1'b1));
        end
      end
      CMD_POP: begin
        if (shadow_top == 0) begin
          empty_hits++;
          pending_results.push_back(shape_result(ST_EMPTY, '0, '0, '0, 1'b1));
        end else begin
          shadow_top--;
          pending_results.push_back(shape_result(ST_OK, shadow_code[shadow_top],
                                                 shadow_age[shadow_top], '0, 1'b1));
        end
      end
      CMD_SEARCH: begin
        for (int i = 0; i < shadow_top; i++) begin
          if (shadow_code[i] == code)
            hits.push_back(shape_result(ST_OK, shadow_code[i], shadow_age[i], '0, 1'b0));
        end
        if (hits.size() == 0) begin
          miss_hits++;
          pending_results.push_back(shape_result(ST_NOT_FOUND, '0, '0, '0, 1'b1));
        end else begin
          hits[hits.size() - 1].last = 1'b1;
          if (hits.size() > longest_match) longest_match = hits.size();
          foreach (hits[i]) pending_results.push_back(hits[i]);
        end
      end
      CMD_SPLIT: begin
        half = shadow_top / 2;
        split_status = ST_OK;
        for (int i = 0; i < half; i++) begin
          shadow_top--;
          if (spill_top >= DEPTH) begin
            split_status = ST_FULL;
          end else begin
            spill_code[spill_top] = shadow_code[shadow_top];
            spill_age[spill_top]  = shadow_age[shadow_top];
            spill_top++;
            track_age_extremes(shadow_age[shadow_top]);
          end
        end
        if (split_status == ST_FULL) lossy_splits++;
        pending_results.push_back(shape_result(split_status, '0, '0, '0, 1'b1));
      end
      CMD_STATS: begin
        if (shadow_top == 0) begin
          empty_hits++;
          pending_results.push_back(shape_result(ST_EMPTY, '0, '0, '0, 1'b1));
        end else begin
          age_sum = 0;
          for (int i = 0; i < shadow_top; i++) age_sum += shadow_age[i];
          pending_results.push_back(shape_result(ST_OK, '0, '0,
                                                 AGE_W'(age_sum / shadow_top), 1'b1));
        end
      end
      default: begin
        pending_results.push_back(shape_result(ST_OK, '0, '0, '0, 1'b1));
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                results_checked, name, got, want));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item arrived with nothing expected");
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", res_if.status, oldest.status);
        check_field("out_code", res_if.out_code, oldest.code);
        check_field("out_age", res_if.out_age, oldest.age);
        check_field("depth_used", res_if.depth_used, oldest.depth);
        check_field("second_used", res_if.second_used, oldest.second);
        check_field("max_age_seen", res_if.max_age_seen, oldest.max_age);
        check_field("min_age_seen", res_if.min_age_seen, oldest.min_age);
        check_field("mean_age", res_if.mean_age, oldest.mean);
        check_field("last", res_if.last, oldest.last);
      end
      results_checked++;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
    end else if (hold_left > 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_wanted) begin
      res_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_wanted  <= 1'b0;
    end else begin
      res_if.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("bounded_stack_with_search_stats_tb failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Called at a rising edge. Leaves valid high after the item is taken, so the
  // caller either sends again at once or drops valid before waiting.
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                           input logic [AGE_W-1:0] age);
    int unsigned gap;
    gap = 0;
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= cmd;
    cmd_if.item_code <= code;
    cmd_if.item_age  <= age;
    do @(posedge clk_i); while (!cmd_if.ready);
    predict_command(cmd, code, age);
    items_sent++;
  endtask

  task automatic pause_until_drained();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Mostly a handful of codes, so that searches hit several entries.
  function automatic logic [CODE_W-1:0] pick_code();
    if ($urandom_range(0, 99) < 70) return CODE_W'($urandom_range(0, 3));
    return CODE_W'($urandom);
  endfunction

  function automatic logic [AGE_W-1:0] pick_age();
    return AGE_W'($urandom);
  endfunction

  task automatic test_empty_stack();
    send_item(CMD_POP, 16'hFFFF, 8'hFF);
    send_item(CMD_STATS, pick_code(), pick_age());
    send_item(CMD_SEARCH, 16'h0000, 8'h00);
    send_item(CMD_SPLIT, pick_code(), pick_age());
    send_item(CMD_SPARE_A, pick_code(), pick_age());
    send_item(CMD_SPARE_B, pick_code(), pick_age());
  endtask

  task automatic test_push_pop_search();
    send_item(CMD_PUSH, 16'h0000, 8'h00);
    send_item(CMD_PUSH, 16'hFFFF, 8'hFF);
    send_item(CMD_PUSH, 16'hFFFF, 8'd100);
    send_item(CMD_SEARCH, 16'hFFFF, 8'h5A);
    send_item(CMD_SEARCH, 16'h0000, 8'hA5);
    send_item(CMD_SEARCH, 16'h0001, 8'h00);
    send_item(CMD_STATS, 16'h0000, 8'h00);
    send_item(CMD_POP, 16'h0000, 8'h00);
    send_item(CMD_POP, 16'h0000, 8'h00);
    send_item(CMD_CLEAR, 16'hFFFF, 8'hFF);
    send_item(CMD_POP, 16'h0000, 8'h00);
  endtask

  // Fills the main stack, pushes past full and splits, three times over, so
  // that the last split finds the spill stack full and drops entries. The
  // result side is held off during the second round.
  task automatic test_fill_and_spill();
    for (int round = 0; round < 3; round++) begin
      if (round == 1) hold_wanted <= 1'b1;
      while (shadow_top < DEPTH) send_item(CMD_PUSH, pick_code(), pick_age());
      send_item(CMD_PUSH, pick_code(), pick_age());
      send_item(CMD_SEARCH, pick_code(), pick_age());
      send_item(CMD_SPLIT, pick_code(), pick_age());
    end
    pause_until_drained();
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned      pick;
    logic [CMD_W-1:0] cmd;
    for (int n = 0; n < count; n++) begin
      steady_flow = (n >= 20 && n < 45);
      pick = $urandom_range(0, 99);
      if (pick < 38)      cmd = CMD_PUSH;
      else if (pick < 53) cmd = CMD_POP;
      else if (pick < 73) cmd = CMD_SEARCH;
      else if (pick < 83) cmd = CMD_STATS;
      else if (pick < 89) cmd = CMD_SPLIT;
      else if (pick < 94) cmd = CMD_CLEAR;
      else if (pick < 97) cmd = CMD_SPARE_A;
      else                cmd = CMD_SPARE_B;
      send_item(cmd, pick_code(), pick_age());
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = CMD_CLEAR;
    cmd_if.item_code = '0;
    cmd_if.item_age  = '0;
    res_if.ready     = 1'b0;
    steady_flow      = 1'b0;
    hold_wanted      = 1'b0;
    shadow_top       = 0;
    spill_top        = 0;
    age_max_seen     = '0;
    age_min_seen     = MIN_NONE;
    fail_count       = 0;
    items_sent       = 0;
    results_checked  = 0;
    stall_cycles     = 0;
    full_hits        = 0;
    empty_hits       = 0;
    miss_hits        = 0;
    lossy_splits     = 0;
    longest_match    = 0;
    foreach (cmd_seen[i]) cmd_seen[i] = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stack();
    test_push_pop_search();
    test_fill_and_spill();
    test_random_mix(75);

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_results.size()));

    $display("Covered %0d commands (push %0d, pop %0d, search %0d, split %0d, stats %0d,",
             items_sent, cmd_seen[CMD_PUSH], cmd_seen[CMD_POP], cmd_seen[CMD_SEARCH],
             cmd_seen[CMD_SPLIT], cmd_seen[CMD_STATS]);
    $display("  clear %0d, spare %0d), %0d results; full %0d, empty %0d, miss %0d, %s %0d",
             cmd_seen[CMD_CLEAR], cmd_seen[CMD_SPARE_A] + cmd_seen[CMD_SPARE_B],
             results_checked, full_hits, empty_hits, miss_hits, "lossy splits",
             lossy_splits);
    if (fail_count == 0) begin
      $display("bounded_stack_with_search_stats_tb passed");
    end else begin
      $display("bounded_stack_with_search_stats_tb failed");
    end
    $finish;
  end

endmodule
